// ===== rtl/core/srrip_pkg.sv =====
// Package: sizes, transaction and row types, and controller commands for the SRRIP bypass block.
`timescale 1ns / 1ps
package srrip_pkg;

    // Geometry
    localparam int NUM_SETS    = 2048;
    localparam int NUM_WAYS    = 16;
    localparam int HIST_LEN    = 32;
    localparam int RRPV_W      = 2;
    localparam int BYPASS_ODDS = 8;

    // Derived widths
    localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int PTR_W = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
    localparam int CNT_W = $clog2(HIST_LEN + 1);
    localparam int CMP_W = 8;

    localparam logic [RRPV_W-1:0] RRPV_MAX = {RRPV_W{1'b1}};
    localparam logic [5:0] THRESH_RESET = 6'd8;

    // Transaction modes
    localparam logic MODE_VICTIM = 1'b0;
    localparam logic MODE_UPDATE = 1'b1;

    // Access type that takes the short insertion
    localparam logic [2:0] TYPE_SHORT = 3'd0;

    typedef struct packed {
        logic        mode;
        logic [10:0] set_index;
        logic [3:0]  way;
        logic        hit;
        logic [2:0]  access_type;
        logic [2:0]  random_draw;
    } t_in_item;

    typedef struct packed {
        logic [3:0] victim_way;
        logic       bypassed;
    } t_out_item;

    // One set's replacement state
    typedef struct packed {
        logic [NUM_WAYS-1:0][RRPV_W-1:0] rrpv;
        logic [HIST_LEN-1:0]             window;
        logic [CNT_W-1:0]                hit_cnt;
        logic [PTR_W-1:0]                ptr;
    } t_set_row;

    localparam t_set_row ROW_RESET = '{
        rrpv:    {NUM_WAYS{RRPV_MAX}},
        window:  '0,
        hit_cnt: '0,
        ptr:     '0
    };

    // Controller to datapath commands
    typedef struct packed {
        logic             clr_we;
        logic [SET_W-1:0] clr_addr;
        logic             accept;
        logic             exec;
    } t_dp_cmd;

endpackage

// ===== rtl/core/srrip_bypass_replacement.sv =====
// Top level: SRRIP replacement state with bypassing in sets that hit rarely.
//
//  Channel  | Signals                              | Direction | Flow control
//  ---------+--------------------------------------+-----------+------------------------
//  in       | i_in_valid, i_in_item, o_in_stall    | input     | valid / stall
//  out      | o_out_valid, o_out_item, i_out_stall | output    | valid / stall
//  cfg      | i_cfg_valid, i_cfg_data, o_cfg_ready | input     | valid / ready
//
// Each transaction first reads the set row from the set memory, then computes
// the new row and writes it back into the same single-port array.
// After reset the block sweeps all NUM_SETS (2048) sets of the set memory, one set
// per cycle, with o_in_stall high; configuration writes are taken meanwhile.
// A result waiting on i_out_stall does not block the next read, only the write-back.
`timescale 1ns / 1ps
module srrip_bypass_replacement
    import srrip_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_in_item   i_in_item,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_out_item  o_out_item,
    input  logic       i_out_stall,
    input  logic       i_cfg_valid,
    input  logic [5:0] i_cfg_data,
    output logic       o_cfg_ready
);

    t_dp_cmd cmd;

    // Register writes are always taken
    assign o_cfg_ready = 1'b1;

    srrip_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    srrip_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_item  (i_in_item),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_out_item (o_out_item)
    );

endmodule

// ===== rtl/core/srrip_ctrl.sv =====
// Controller: clearing pass after reset, item sequencing and output valid.
`timescale 1ns / 1ps
module srrip_ctrl
    import srrip_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_dp_cmd o_cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [SET_W-1:0] r_clr_addr, n_clr_addr;
    logic             r_out_valid, n_out_valid;
    logic             out_free;
    logic             accept;
    logic             exec;

    assign out_free = !r_out_valid || !i_out_stall;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        accept     = 1'b0;
        exec       = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == SET_W'(NUM_SETS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    accept  = 1'b1;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    exec    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold the result valid until taken
    always_comb begin
        if (exec) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_cmd.clr_we   = (r_state == ST_CLEAR);
    assign o_cmd.clr_addr = r_clr_addr;
    assign o_cmd.accept   = accept;
    assign o_cmd.exec     = exec;

endmodule

// ===== rtl/core/srrip_dp.sv =====
// Datapath: set state memory, victim selection, outcome window update and result register.
`timescale 1ns / 1ps
module srrip_dp
    import srrip_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    input  t_in_item  i_in_item,
    input  logic      i_cfg_we,
    input  logic [5:0] i_cfg_data,
    output t_out_item o_out_item
);

    t_set_row mem [NUM_SETS];

    t_set_row         r_row;
    t_in_item         r_item;
    logic [SET_W-1:0] r_set;
    logic [5:0]       r_bad_thresh;
    t_out_item        r_out;

    logic [SET_W-1:0]  rd_set;
    logic [RRPV_W-1:0] top;
    logic [RRPV_W-1:0] age;
    logic [WAY_W-1:0]  vic;
    logic              found;
    logic [WAY_W-1:0]  upd_way;
    logic              old_bit;
    logic [CNT_W-1:0]  new_cnt;
    logic              bad;
    logic              bypass;
    t_set_row          n_row;
    t_out_item         n_out;

    assign rd_set = SET_W'(i_in_item.set_index % NUM_SETS);

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bad_thresh <= THRESH_RESET;
        end else if (i_cfg_we) begin
            r_bad_thresh <= i_cfg_data;
        end
    end

    // Set memory: clear sweep or write-back, registered read on accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_we) begin
            mem[i_cmd.clr_addr] <= ROW_RESET;
        end else if (i_cmd.exec) begin
            mem[r_set] <= n_row;
        end
        if (i_cmd.accept) begin
            r_row <= mem[rd_set];
        end
    end

    // Latch the accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_in_item;
            r_set  <= rd_set;
        end
    end

    // Victim search: largest value, then lowest way holding it
    always_comb begin
        top   = '0;
        vic   = '0;
        found = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (r_row.rrpv[w] > top) begin
                top = r_row.rrpv[w];
            end
        end
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (!found && (r_row.rrpv[w] == top)) begin
                vic   = WAY_W'(w);
                found = 1'b1;
            end
        end
        age = RRPV_MAX - top;
    end

    // Outcome window and insertion decision
    assign upd_way = WAY_W'(r_item.way % NUM_WAYS);
    assign old_bit = r_row.window[r_row.ptr];
    assign new_cnt = r_row.hit_cnt - CNT_W'(old_bit) + CNT_W'(r_item.hit);
    assign bad     = CMP_W'(new_cnt) <= CMP_W'(r_bad_thresh);
    assign bypass  = !r_item.hit && bad && ((r_item.random_draw % BYPASS_ODDS) == 0);

    // Build the new row and the result
    always_comb begin
        n_row = r_row;
        n_out = '0;
        if (r_item.mode == MODE_VICTIM) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                n_row.rrpv[w] = r_row.rrpv[w] + age;
            end
            n_out.victim_way = 4'(vic);
        end else begin
            n_row.window[r_row.ptr] = r_item.hit;
            n_row.hit_cnt           = new_cnt;
            if (r_row.ptr == PTR_W'(HIST_LEN - 1)) begin
                n_row.ptr = '0;
            end else begin
                n_row.ptr = r_row.ptr + 1'b1;
            end
            if (r_item.hit) begin
                n_row.rrpv[upd_way] = '0;
            end else if (bypass || (r_item.access_type != TYPE_SHORT)) begin
                n_row.rrpv[upd_way] = RRPV_MAX;
            end else begin
                n_row.rrpv[upd_way] = RRPV_MAX - 1'b1;
            end
            n_out.bypassed = bypass;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out <= n_out;
        end
    end

    assign o_out_item = r_out;

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for srrip_bypass_replacement: directed and random traffic checked against a predictor.
`timescale 1ns / 1ps
module tb_top;
    import srrip_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 310;

    typedef enum int {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_HEAVY} t_stall_style;

    // DUT connections, all inputs driven to known values from time zero
    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    t_in_item   i_in_item   = '0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_item  o_out_item;
    logic       i_out_stall = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [5:0] i_cfg_data  = '0;
    logic       o_cfg_ready;

    // Predicted replacement state and register copy
    logic [NUM_WAYS-1:0][RRPV_W-1:0] rrpv_shadow [NUM_SETS];
    logic [HIST_LEN-1:0]             outcome_shadow [NUM_SETS];
    int unsigned                     hits_shadow [NUM_SETS];
    logic [PTR_W-1:0]                ptr_shadow [NUM_SETS];
    logic [5:0]                      threshold_shadow;

    t_out_item    pending_results[$];
    t_out_item    last_prediction;
    t_out_item    due;
    int           error_count = 0;
    int           cycle_count = 0;
    int           burst_left  = 0;
    bit           sender_busy = 1'b0;
    int           stall_left  = 0;
    t_stall_style stall_style = STALL_NONE;

    srrip_bypass_replacement uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver back-pressure: switch between randomly chosen stall styles at random intervals
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_style = t_stall_style'($urandom_range(0, 3));
            stall_left  = $urandom_range(16, 96);
        end
        stall_left--;
        case (stall_style)
            STALL_NONE:     i_out_stall <= 1'b0;
            STALL_COIN:     i_out_stall <= ($urandom_range(0, 1) == 1);
            STALL_PERIODIC: i_out_stall <= ((stall_left % 3) != 0);
            default:        i_out_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with no transaction outstanding: victim_way %0d bypassed %0d",
                       o_out_item.victim_way, o_out_item.bypassed);
                error_count++;
            end else begin
                due = pending_results.pop_front();
                if (o_out_item.victim_way !== due.victim_way) begin
                    $error("victim_way: expected %0d, got %0d",
                           due.victim_way, o_out_item.victim_way);
                    error_count++;
                end
                if (o_out_item.bypassed !== due.bypassed) begin
                    $error("bypassed: expected %0d, got %0d", due.bypassed, o_out_item.bypassed);
                    error_count++;
                end
            end
        end
    end

    // Advance the shadow state by one transaction and return its result
    function automatic t_out_item predict_replacement(input t_in_item it);
        t_out_item        res;
        int               s;
        int               w;
        int               top;
        int               age;
        logic [PTR_W-1:0] p;
        res = '0;
        s   = it.set_index;
        w   = it.way;
        if (it.mode == MODE_VICTIM) begin
            top = 0;
            for (int k = 0; k < NUM_WAYS; k++) begin
                if (int'(rrpv_shadow[s][k]) > top) top = rrpv_shadow[s][k];
            end
            // age the whole set so that at least one way reaches the maximum
            if (top < int'(RRPV_MAX)) begin
                age = int'(RRPV_MAX) - top;
                for (int k = 0; k < NUM_WAYS; k++) begin
                    rrpv_shadow[s][k] = rrpv_shadow[s][k] + RRPV_W'(age);
                end
            end
            // scan downward so the lowest way at maximum wins
            for (int k = NUM_WAYS - 1; k >= 0; k--) begin
                if (rrpv_shadow[s][k] == RRPV_MAX) res.victim_way = 4'(k);
            end
        end else begin
            // slide the outcome window
            p = ptr_shadow[s];
            if (outcome_shadow[s][p]) hits_shadow[s]--;
            outcome_shadow[s][p] = it.hit;
            if (it.hit) hits_shadow[s]++;
            ptr_shadow[s] = p + 1'b1;
            if (it.hit) begin
                rrpv_shadow[s][w] = '0;
            end else begin
                if (hits_shadow[s] <= threshold_shadow && (it.random_draw % BYPASS_ODDS) == 0) begin
                    res.bypassed = 1'b1;
                end
                if (res.bypassed || it.access_type != TYPE_SHORT) begin
                    rrpv_shadow[s][w] = RRPV_MAX;
                end else begin
                    rrpv_shadow[s][w] = RRPV_MAX - 1'b1;
                end
            end
        end
        return res;
    endfunction

    function automatic t_in_item make_item(input logic mode, input logic [10:0] set_index,
                                           input logic [3:0] way, input logic hit,
                                           input logic [2:0] access_type,
                                           input logic [2:0] random_draw);
        t_in_item it;
        it.mode        = mode;
        it.set_index   = set_index;
        it.way         = way;
        it.hit         = hit;
        it.access_type = access_type;
        it.random_draw = random_draw;
        return it;
    endfunction

    // Send one transaction, predict it on acceptance, then idle per the burst pattern
    task automatic send_item(input t_in_item it);
        int gap;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        last_prediction = predict_replacement(it);
        pending_results.push_back(last_prediction);
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!sender_busy) gap = $urandom_range(1, 6);
        end else begin
            burst_left--;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold the input side until every outstanding result has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [5:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        threshold_shadow = value;
        i_cfg_valid <= 1'b0;
    endtask

    // Cache-like traffic on a small pool of sets plus random noise
    task automatic run_traffic(input int item_total);
        int               sent;
        int               rate_left;
        int               hit_pct;
        logic [SET_W-1:0] pool [8];
        logic [SET_W-1:0] set_sel;
        logic [31:0]      raw;
        t_in_item         it;
        sent      = 0;
        rate_left = 0;
        hit_pct   = 50;
        foreach (pool[i]) begin
            raw     = $urandom;
            pool[i] = raw[SET_W-1:0];
        end
        while (sent < item_total) begin
            if (rate_left == 0) begin
                hit_pct   = $urandom_range(0, 100);
                rate_left = $urandom_range(20, 60);
            end
            rate_left--;
            raw     = $urandom;
            set_sel = pool[raw[2:0]];
            if ($urandom_range(0, 99) < 12) begin
                // noise: any field combination, any set
                raw = $urandom;
                it  = raw[$bits(t_in_item)-1:0];
                send_item(it);
                sent++;
            end else if ($urandom_range(0, 99) < hit_pct) begin
                raw = $urandom;
                send_item(make_item(MODE_UPDATE, set_sel, raw[3:0], 1'b1, raw[6:4], raw[9:7]));
                sent++;
            end else begin
                // miss: ask for a victim, then fill that way
                raw = $urandom;
                send_item(make_item(MODE_VICTIM, set_sel, raw[3:0], raw[4], raw[7:5], raw[10:8]));
                raw = $urandom;
                send_item(make_item(MODE_UPDATE, set_sel, last_prediction.victim_way, 1'b0,
                                    raw[0] ? TYPE_SHORT : raw[3:1], raw[6:4]));
                sent += 2;
            end
            if ($urandom_range(0, 199) == 0) wait_drained();
        end
    endtask

    // Fresh set at the top index: field extremes, bypass in a bad set, hit never bypassed
    task automatic test_fresh_set_extremes();
        send_item(make_item(MODE_VICTIM, 11'd2047, 4'd15, 1'b1, 3'd7, 3'd7));
        send_item(make_item(MODE_UPDATE, 11'd2047, 4'd15, 1'b1, TYPE_SHORT, 3'd0));
        send_item(make_item(MODE_UPDATE, 11'd2047, 4'd0, 1'b0, TYPE_SHORT, 3'd0));
        send_item(make_item(MODE_UPDATE, 11'd2047, 4'd1, 1'b0, TYPE_SHORT, 3'd7));
        send_item(make_item(MODE_UPDATE, 11'd2047, 4'd2, 1'b0, 3'd5, 3'd0));
        send_item(make_item(MODE_VICTIM, 11'd0, 4'd0, 1'b0, 3'd0, 3'd0));
        send_item(make_item(MODE_VICTIM, 11'd2047, 4'd0, 1'b0, 3'd0, 3'd0));
    endtask

    // Fill a set so no way is at maximum; the victim request must age it
    task automatic test_aging_victim();
        for (int k = 0; k < NUM_WAYS - 1; k++) begin
            send_item(make_item(MODE_UPDATE, 11'd5, 4'(k), 1'b1, 3'd3, 3'd4));
        end
        // good set: a zero draw must not bypass
        send_item(make_item(MODE_UPDATE, 11'd5, 4'd15, 1'b0, TYPE_SHORT, 3'd0));
        send_item(make_item(MODE_VICTIM, 11'd5, 4'd0, 1'b0, 3'd0, 3'd0));
        send_item(make_item(MODE_VICTIM, 11'd5, 4'd0, 1'b0, 3'd0, 3'd0));
    endtask

    // Threshold extremes: only empty windows bad, then every set bad
    task automatic test_threshold_extremes();
        write_threshold(6'd0);
        run_traffic(PHASE_ITEMS);
        write_threshold(6'd63);
        sender_busy = 1'b1;
        run_traffic(PHASE_ITEMS);
        sender_busy = 1'b0;
        write_threshold(6'd32);
        run_traffic(PHASE_ITEMS);
    endtask

    // Mid-range thresholds with the sender mostly idle-free in stretches
    task automatic test_mixed_traffic();
        logic [31:0] raw;
        raw = $urandom_range(1, 31);
        write_threshold(raw[5:0]);
        run_traffic(PHASE_ITEMS);
        write_threshold(THRESH_RESET);
        sender_busy = 1'b1;
        run_traffic(PHASE_ITEMS / 2);
        sender_busy = 1'b0;
        run_traffic(PHASE_ITEMS - PHASE_ITEMS / 2);
    endtask

    initial begin
        for (int s = 0; s < NUM_SETS; s++) begin
            rrpv_shadow[s]    = {NUM_WAYS{RRPV_MAX}};
            outcome_shadow[s] = '0;
            hits_shadow[s]    = 0;
            ptr_shadow[s]     = '0;
        end
        threshold_shadow = THRESH_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fresh_set_extremes();
        test_aging_victim();
        test_threshold_extremes();
        test_mixed_traffic();

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
